// ===== design/aggregated_bitmap_encoder_unit_defines.svh =====
// Assertion macros for the file that checks the encoder.
`ifndef AGGREGATED_BITMAP_ENCODER_UNIT_DEFINES_SVH
`define AGGREGATED_BITMAP_ENCODER_UNIT_DEFINES_SVH

// Check that c holds in the same cycle whenever a holds.
`define ABE_ASSERT_SAME(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("abe assertion failed");

// Check that c holds in the cycle after a holds.
`define ABE_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("abe assertion failed");

`endif

// ===== design/abe_pkg.sv =====
package abe_pkg;

    localparam int WORD_W      = 32;
    localparam int CFG_W       = 11;
    localparam int POS_W       = 10;
    localparam int GROUP_BITS  = 5;
    localparam int RESULTS_MAX = 3;
    localparam int OUT_DATA_W  = 48;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [1:0] {
        KIND_DETAIL  = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_COUNT   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] value;
        logic              end_of_bitmap;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r2;
        result_t    r1;
        result_t    r0;
    } bundle_t;

endpackage

// ===== design/abe_core.sv =====
module abe_core #(
    parameter int MAX_WORDS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [abe_pkg::WORD_W-1:0] word,
    input  logic [abe_pkg::CFG_W-1:0]  bitmap_words,
    output abe_pkg::bundle_t          bundle
);
    import abe_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORDS);
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int LEN_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

    logic [WORD_W-1:0] summary_acc_reg, summary_acc_next;
    logic [IDX_W-1:0]  word_index_reg, word_index_next;
    logic [CNT_W-1:0]  detail_count_reg, detail_count_next;

    logic [LEN_W-1:0]  cfg_ext;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  idx_plus;
    logic              last;
    logic              nonzero;
    logic              group_end;
    logic [WORD_W-1:0] acc_set;
    logic [15:0]       idx_ext;
    logic [15:0]       cnt_ext;
    logic [CNT_W-1:0]  cnt_inc;
    result_t           slot [RESULTS_MAX];
    logic [1:0]        n;

    always_comb
    begin
        cfg_ext = LEN_W'(bitmap_words);
        if (cfg_ext == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg_ext > LEN_W'(MAX_WORDS))
        begin
            len = LEN_W'(MAX_WORDS);
        end
        else
        begin
            len = cfg_ext;
        end
        idx_plus  = LEN_W'(word_index_reg) + LEN_W'(1);
        last      = idx_plus >= len;
        nonzero   = word != '0;
        group_end = word_index_reg[GROUP_BITS-1:0] == {GROUP_BITS{1'b1}};
        idx_ext   = 16'(word_index_reg);
        cnt_ext   = 16'(detail_count_reg);
        acc_set   = summary_acc_reg;
        cnt_inc   = detail_count_reg;
        if (nonzero)
        begin
            acc_set = summary_acc_reg | (WORD_W'(1) << word_index_reg[GROUP_BITS-1:0]);
            cnt_inc = detail_count_reg + CNT_W'(1);
        end

        for (int k = 0; k < RESULTS_MAX; k++)
        begin
            slot[k] = '0;
        end
        n = 2'd0;
        if (nonzero)
        begin
            slot[n].kind          = KIND_DETAIL;
            slot[n].position      = cnt_ext[POS_W-1:0];
            slot[n].value         = word;
            slot[n].end_of_bitmap = 1'b0;
            n = n + 2'd1;
        end
        if (group_end || last)
        begin
            slot[n].kind          = KIND_SUMMARY;
            slot[n].position      = idx_ext[GROUP_BITS+POS_W-1:GROUP_BITS];
            slot[n].value         = acc_set;
            slot[n].end_of_bitmap = 1'b0;
            n = n + 2'd1;
        end
        if (last)
        begin
            slot[n].kind          = KIND_COUNT;
            slot[n].position      = '0;
            slot[n].value         = WORD_W'(cnt_inc);
            slot[n].end_of_bitmap = 1'b1;
            n = n + 2'd1;
        end
        bundle.count = n;
        bundle.r0    = slot[0];
        bundle.r1    = slot[1];
        bundle.r2    = slot[2];

        summary_acc_next  = (group_end || last) ? '0 : acc_set;
        word_index_next   = last ? '0 : word_index_reg + IDX_W'(1);
        detail_count_next = last ? '0 : cnt_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_acc_reg  <= '0;
            word_index_reg   <= '0;
            detail_count_reg <= '0;
        end
        else if (take)
        begin
            summary_acc_reg  <= summary_acc_next;
            word_index_reg   <= word_index_next;
            detail_count_reg <= detail_count_next;
        end
    end

endmodule

// ===== design/abe_out_seq.sv =====
module abe_out_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  abe_pkg::bundle_t bundle,
    input  logic             pop_ready,
    output logic             room,
    output logic             out_valid,
    output abe_pkg::result_t out_result
);
    import abe_pkg::*;

    result_t    slot_reg [RESULTS_MAX];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid  = cnt_reg != 2'd0;
    assign out_result = slot_reg[0];
    assign pop        = out_valid && pop_ready;
    assign room       = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop_ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = bundle.count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // load a new bundle or advance the queue
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg[0] <= bundle.r0;
            slot_reg[1] <= bundle.r1;
            slot_reg[2] <= bundle.r2;
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

// ===== design/aggregated_bitmap_encoder_unit.sv =====
// Aggregated bitmap encoder. Each plain word accepted on s_axis gives, in
// order, a detail result when the word is nonzero, a summary result when it
// closes a group of 32 words or the bitmap, and a count result (tlast high)
// when it closes the bitmap; tuser carries the result kind. An item waits in
// the input register until the result buffer has room, then moves through
// the combinational encoder into the buffer, so its first result is
// presented from the buffer once the item has passed the input register.
// Throughput is one item per cycle while each item yields at most one
// result and m_axis_tready stays high; each extra result in an item holds
// back the next item, as the output register sends one result per cycle
// while m_axis_tready is high. A zero word inside a group yields no result.
// Write bitmap_words on the cfg channel only while the block is idle.
module aggregated_bitmap_encoder_unit #(
    parameter int MAX_WORDS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [abe_pkg::CFG_W-1:0]     cfg_data,       // bitmap_words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [abe_pkg::WORD_W-1:0]    s_axis_tdata,   // plain_word
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [abe_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // position, value, zero pad
    output logic [1:0]                    m_axis_tuser,   // kind
    output logic                          m_axis_tlast    // end_of_bitmap
);
    import abe_pkg::*;

    `include "aggregated_bitmap_encoder_unit_defines.svh"

    logic [CFG_W-1:0]  bitmap_words_reg;
    logic              in_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic              take;
    logic              room;
    bundle_t           bundle;
    result_t           out_result;
    logic              out_count;

    assign cfg_ready     = 1'b1;
    assign take          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_words_reg <= CFG_RESET;
            in_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                bitmap_words_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    // hold the item until the encoder takes it
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            word_reg <= s_axis_tdata;
        end
    end

    abe_core #(
        .MAX_WORDS (MAX_WORDS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .word         (word_reg),
        .bitmap_words (bitmap_words_reg),
        .bundle       (bundle)
    );

    abe_out_seq u_out_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .bundle     (bundle),
        .pop_ready  (m_axis_tready),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_result (out_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - WORD_W - POS_W){1'b0}},
                           out_result.value, out_result.position};
    assign m_axis_tuser = out_result.kind;
    assign m_axis_tlast = out_result.end_of_bitmap;

    assign out_count = m_axis_tvalid && m_axis_tuser == KIND_COUNT;

    `ABE_ASSERT_SAME(a_last_is_count, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_COUNT)
    `ABE_ASSERT_SAME(a_count_pos_zero, out_count, m_axis_tlast && out_result.position == '0)
    `ABE_ASSERT_NEXT(a_stall_holds_item, in_valid_reg && !room, in_valid_reg && $stable(word_reg))

endmodule
